// File: src/fpes_pkg.sv
// ----------------------------------------------------------------------------
// fpes_pkg
// Shared types and constants for the flash program/erase sequencer.
// ----------------------------------------------------------------------------
package fpes_pkg;

  localparam int SectorBytes   = 4096;
  localparam int PageBytes     = 256;
  localparam int SectorBits    = $clog2(SectorBytes);
  localparam int PageBits      = $clog2(PageBytes);
  localparam int AddrW         = 24;
  localparam int LenW          = 13;
  localparam int ChunkW        = 9;
  localparam int OffW          = 12;
  localparam int PollW         = 9;
  localparam int SizeLog2Max   = 24;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrW     = $clog2(QueueDepth);

  localparam logic [PollW-1:0] PollsProgram = PollW'(100);
  localparam logic [PollW-1:0] PollsErase   = PollW'(400);

  localparam logic CfgSizeLog2   = 1'b0;
  localparam logic CfgChunkLimit = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ERASE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_WRITE_ENABLE = 3'd0,
    ACT_READ_STATUS  = 3'd1,
    ACT_PAGE_PROGRAM = 3'd2,
    ACT_SECTOR_ERASE = 3'd3,
    ACT_FINISHED     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_ADDR        = 3'd1,
    ERR_CROSS       = 3'd2,
    ERR_WEL         = 3'd3,
    ERR_TIMEOUT     = 3'd4
  } err_t;

  localparam int StBusyBit = 0;
  localparam int StWelBit  = 1;

  typedef struct packed {
    action_t             action;
    logic [AddrW-1:0]    target_address;
    logic [ChunkW-1:0]   chunk_length;
    logic [OffW-1:0]     buffer_offset;
    err_t                error_code;
    logic                last;
  } result_t;

endpackage

// File: src/flash_program_erase_sequencer.sv
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer
// Sequences SPI NOR page programs and 4k sector erases from event inputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one event per transaction: in_tuser is the opcode
//   (write request, erase request, status byte, millisecond tick), in_tdata
//   holds address, length and status byte. Each event yields zero, one or
//   two result transactions on the output stream; out_tuser is the flash
//   action, out_tdata its address, chunk length, buffer offset and error
//   code, out_tlast marks the final result of an event.
//   Configuration writes (flash size log2, chunk limit) use the cfg_ port, always
//   ready. The user must make them while the block is idle; it is not enforced.
//   An event is evaluated in the cycle it is accepted; its results are
//   written to a four-entry result queue and, when the queue was empty, the
//   first one is visible on the output the next cycle. One event per cycle
//   is accepted while the queue has room for two results, so throughput is
//   one event per cycle, bounded by one result per cycle on the output.
//   When the receiver stalls, the queue fills and in_tready drops until
//   space for two results returns. Reset empties the queue, returns the
//   sequencer to idle and loads flash size 2^24 and chunk limit 256.
// ----------------------------------------------------------------------------
module flash_program_erase_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[23:0], length[36:24], status_byte[44:37]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // target_address[23:0], chunk_length[32:24],
                                  // buffer_offset[44:33], error_code[47:45]
  output logic [2:0]  out_tuser,  // action[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_WEL,
    PH_WAIT_TICK,
    PH_WAIT_POLL
  } phase_t;

  localparam int   AW = fpes_pkg::AddrW;
  localparam int   LW = fpes_pkg::LenW;
  localparam int   CW = fpes_pkg::ChunkW;
  localparam int   OW = fpes_pkg::OffW;
  localparam int   QW = fpes_pkg::QueuePtrW;

  logic [4:0]              size_log2_r;
  logic [CW-1:0]           chunk_limit_r;
  phase_t                  phase_r, phase_nxt;
  logic                    is_erase_r, is_erase_nxt;
  logic [AW-1:0]           cur_addr_r, cur_addr_nxt;
  logic [LW-1:0]           bytes_left_r, bytes_left_nxt;
  logic [OW-1:0]           bytes_done_r, bytes_done_nxt;
  logic [fpes_pkg::PollW-1:0] polls_left_r, polls_left_nxt, polls_dec;

  fpes_pkg::result_t       queue_r [fpes_pkg::QueueDepth];
  logic [QW-1:0]           wr_ptr_r, rd_ptr_r;
  logic [QW:0]             count_r;

  fpes_pkg::result_t       res0, res1;
  logic [1:0]              n_push;
  logic                    in_fire, out_fire;

  fpes_pkg::opcode_t       op;
  logic [AW-1:0]           in_addr;
  logic [LW-1:0]           in_len;
  logic [7:0]              in_status;

  logic [4:0]              lg;
  logic [AW:0]             flash_size;
  logic [AW:0]             size_room;
  logic [fpes_pkg::SectorBits:0] sector_room;
  logic [CW-1:0]           lim, page_room, chunk_a;
  logic [CW-1:0]           chunk;
  logic [LW-1:0]           left_after;

  assign op        = fpes_pkg::opcode_t'(in_tuser);
  assign in_addr   = in_tdata[AW-1:0];
  assign in_len    = in_tdata[AW+LW-1:AW];
  assign in_status = in_tdata[AW+LW+7:AW+LW];

  assign in_tready = (count_r <= (QW+1)'(fpes_pkg::QueueDepth - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  assign out_tuser = queue_r[rd_ptr_r].action;
  assign out_tdata = {queue_r[rd_ptr_r].error_code, queue_r[rd_ptr_r].buffer_offset,
                      queue_r[rd_ptr_r].chunk_length, queue_r[rd_ptr_r].target_address};
  assign out_tlast = queue_r[rd_ptr_r].last;

  // Request checks
  always_comb begin
    lg          = (size_log2_r > 5'(fpes_pkg::SizeLog2Max)) ?
                  5'(fpes_pkg::SizeLog2Max) : size_log2_r;
    flash_size  = (AW+1)'(1) << lg;
    size_room   = flash_size - {1'b0, in_addr};
    sector_room = (fpes_pkg::SectorBits+1)'(fpes_pkg::SectorBytes)
                - {1'b0, in_addr[fpes_pkg::SectorBits-1:0]};
  end

  // Chunk size at the current address
  always_comb begin
    lim       = (chunk_limit_r == '0) ? CW'(1) : chunk_limit_r;
    page_room = CW'(fpes_pkg::PageBytes)
              - CW'(cur_addr_r[fpes_pkg::PageBits-1:0]);
    chunk_a   = (page_room > lim) ? lim : page_room;
    chunk     = (LW'(chunk_a) > bytes_left_r) ? CW'(bytes_left_r) : chunk_a;
    left_after = bytes_left_r - LW'(chunk);
    polls_dec = (polls_left_r != '0) ? polls_left_r - 1'b1 : polls_left_r;
  end

  function automatic fpes_pkg::result_t mk_result(fpes_pkg::action_t act,
                                                  logic [AW-1:0] adr,
                                                  logic [CW-1:0] len,
                                                  logic [OW-1:0] off,
                                                  fpes_pkg::err_t err,
                                                  logic lst);
    fpes_pkg::result_t r;
    r.action         = act;
    r.target_address = adr;
    r.chunk_length   = len;
    r.buffer_offset  = off;
    r.error_code     = err;
    r.last           = lst;
    return r;
  endfunction

  always_comb begin
    phase_nxt      = phase_r;
    is_erase_nxt   = is_erase_r;
    cur_addr_nxt   = cur_addr_r;
    bytes_left_nxt = bytes_left_r;
    bytes_done_nxt = bytes_done_r;
    polls_left_nxt = polls_left_r;
    n_push         = 2'd0;
    res0 = mk_result(fpes_pkg::ACT_WRITE_ENABLE, '0, '0, '0, fpes_pkg::ERR_OK, 1'b0);
    res1 = mk_result(fpes_pkg::ACT_READ_STATUS, '0, '0, '0, fpes_pkg::ERR_OK, 1'b1);
    unique case (phase_r)
      PH_IDLE: begin
        if (op == fpes_pkg::OP_WRITE) begin
          if (({1'b0, in_addr} > flash_size) || ((AW+1)'(in_len) > size_room)) begin
            n_push = 2'd1;
            res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0, fpes_pkg::ERR_ADDR, 1'b1);
          end else if (in_len > LW'(sector_room)) begin
            n_push = 2'd1;
            res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0, fpes_pkg::ERR_CROSS, 1'b1);
          end else if (in_len == '0) begin
            n_push = 2'd1;
            res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0, fpes_pkg::ERR_OK, 1'b1);
          end else begin
            n_push         = 2'd2;
            is_erase_nxt   = 1'b0;
            cur_addr_nxt   = in_addr;
            bytes_left_nxt = in_len;
            bytes_done_nxt = '0;
            phase_nxt      = PH_WAIT_WEL;
          end
        end else if (op == fpes_pkg::OP_ERASE) begin
          n_push         = 2'd2;
          is_erase_nxt   = 1'b1;
          cur_addr_nxt   = in_addr;
          bytes_left_nxt = '0;
          bytes_done_nxt = '0;
          phase_nxt      = PH_WAIT_WEL;
        end
      end
      PH_WAIT_WEL: begin
        if (op == fpes_pkg::OP_STATUS) begin
          n_push = 2'd1;
          if (!in_status[fpes_pkg::StWelBit]) begin
            res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0, fpes_pkg::ERR_WEL, 1'b1);
            phase_nxt = PH_IDLE;
          end else if (is_erase_r) begin
            res0 = mk_result(fpes_pkg::ACT_SECTOR_ERASE, cur_addr_r, '0, '0,
                             fpes_pkg::ERR_OK, 1'b1);
            polls_left_nxt = fpes_pkg::PollsErase;
            phase_nxt      = PH_WAIT_TICK;
          end else begin
            res0 = mk_result(fpes_pkg::ACT_PAGE_PROGRAM, cur_addr_r, chunk, bytes_done_r,
                             fpes_pkg::ERR_OK, 1'b1);
            polls_left_nxt = fpes_pkg::PollsProgram;
            phase_nxt      = PH_WAIT_TICK;
          end
        end
      end
      PH_WAIT_TICK: begin
        if (op == fpes_pkg::OP_TICK) begin
          n_push    = 2'd1;
          res0 = mk_result(fpes_pkg::ACT_READ_STATUS, '0, '0, '0, fpes_pkg::ERR_OK, 1'b1);
          phase_nxt = PH_WAIT_POLL;
        end
      end
      PH_WAIT_POLL: begin
        if (op == fpes_pkg::OP_STATUS) begin
          if (!in_status[fpes_pkg::StBusyBit]) begin
            if (is_erase_r) begin
              n_push    = 2'd1;
              res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0, fpes_pkg::ERR_OK, 1'b1);
              phase_nxt = PH_IDLE;
            end else begin
              cur_addr_nxt   = cur_addr_r + AW'(chunk);
              bytes_done_nxt = bytes_done_r + OW'(chunk);
              bytes_left_nxt = left_after;
              if (left_after == '0) begin
                n_push    = 2'd1;
                res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0,
                                 fpes_pkg::ERR_OK, 1'b1);
                phase_nxt = PH_IDLE;
              end else begin
                n_push    = 2'd2;
                phase_nxt = PH_WAIT_WEL;
              end
            end
          end else begin
            polls_left_nxt = polls_dec;
            if (polls_dec == '0) begin
              n_push    = 2'd1;
              res0 = mk_result(fpes_pkg::ACT_FINISHED, '0, '0, '0,
                               fpes_pkg::ERR_TIMEOUT, 1'b1);
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_WAIT_TICK;
            end
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r   <= 5'(fpes_pkg::SizeLog2Max);
      chunk_limit_r <= CW'(fpes_pkg::PageBytes);
      phase_r       <= PH_IDLE;
      is_erase_r    <= 1'b0;
      cur_addr_r    <= '0;
      bytes_left_r  <= '0;
      bytes_done_r  <= '0;
      polls_left_r  <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fpes_pkg::CfgSizeLog2:   size_log2_r <= cfg_data[4:0];
          fpes_pkg::CfgChunkLimit: chunk_limit_r <= cfg_data;
          default:                 ;
        endcase
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        is_erase_r   <= is_erase_nxt;
        cur_addr_r   <= cur_addr_nxt;
        bytes_left_r <= bytes_left_nxt;
        bytes_done_r <= bytes_done_nxt;
        polls_left_r <= polls_left_nxt;
        wr_ptr_r     <= wr_ptr_r + QW'(n_push);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (in_fire ? (QW+1)'(n_push) : '0)
               - (out_fire ? (QW+1)'(1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (n_push != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (in_fire && (n_push == 2'd2)) begin
      queue_r[wr_ptr_r + 1'b1] <= res1;
    end
  end

endmodule

// File: tb/flash_program_erase_sequencer_tb.sv
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer_tb
// Self-checking bench for the flash program/erase sequencer. Drives event
// transactions (requests, status bytes, ticks) with random gaps, stalls the
// result stream at random, and checks each result against a cycle-free
// model of the sequencer kept in a small scoreboard. Runs a directed opening,
// then random program and erase sequences, with malformed requests and stray
// events, under several register settings, including a full erase timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module flash_program_erase_sequencer_tb;

  localparam int AW              = fpes_pkg::AddrW;
  localparam int LW              = fpes_pkg::LenW;
  localparam int CW              = fpes_pkg::ChunkW;
  localparam int OW              = fpes_pkg::OffW;
  localparam int PW              = fpes_pkg::PollW;
  localparam int WatchdogLimit   = 1000;
  localparam int ItemsPerSetting = 50;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WAIT_WEL,
    SEQ_WAIT_TICK,
    SEQ_WAIT_POLL
  } seq_phase_t;

  class flash_action_scoreboard;
    logic [4:0]        size_log2;
    logic [8:0]        chunk_limit;
    seq_phase_t        phase;
    bit                is_erase;
    logic [AW-1:0]     cur_addr;
    logic [LW-1:0]     bytes_left;
    logic [OW-1:0]     bytes_done;
    logic [PW-1:0]     polls_left;
    fpes_pkg::result_t expected_actions[$];
    int                errors;
    int                n_events;
    int                n_results;
    int                finishes[5];

    function new();
      size_log2   = 5'd24;
      chunk_limit = 9'd256;
      phase       = SEQ_IDLE;
      is_erase    = 1'b0;
      cur_addr    = '0;
      bytes_left  = '0;
      bytes_done  = '0;
      polls_left  = '0;
      errors      = 0;
      n_events    = 0;
      n_results   = 0;
      foreach (finishes[i]) finishes[i] = 0;
    endfunction

    function void write_reg(bit idx, logic [8:0] val);
      if (idx == fpes_pkg::CfgSizeLog2) size_log2 = val[4:0];
      else chunk_limit = val;
    endfunction

    function int chunk_bytes();
      int lim;
      int m;
      lim = (chunk_limit == 0) ? 1 : int'(chunk_limit);
      m = fpes_pkg::PageBytes - int'(cur_addr % fpes_pkg::PageBytes);
      if (m > lim) m = lim;
      if (m > bytes_left) m = bytes_left;
      return m;
    endfunction

    function void push(fpes_pkg::action_t act, logic [AW-1:0] adr, logic [CW-1:0] len,
                       logic [OW-1:0] off, fpes_pkg::err_t err);
      fpes_pkg::result_t r;
      r.action         = act;
      r.target_address = adr;
      r.chunk_length   = len;
      r.buffer_offset  = off;
      r.error_code     = err;
      r.last           = 1'b0;
      expected_actions.push_back(r);
    endfunction

    function void finish_op(fpes_pkg::err_t err);
      push(fpes_pkg::ACT_FINISHED, '0, '0, '0, err);
      finishes[int'(err)]++;
      phase = SEQ_IDLE;
    endfunction

    function void start_enable();
      push(fpes_pkg::ACT_WRITE_ENABLE, '0, '0, '0, fpes_pkg::ERR_OK);
      push(fpes_pkg::ACT_READ_STATUS, '0, '0, '0, fpes_pkg::ERR_OK);
      phase = SEQ_WAIT_WEL;
    endfunction

    // Returns 1 when the event produced results or moved the sequence.
    function bit note_event(fpes_pkg::opcode_t op, logic [AW-1:0] adr, logic [LW-1:0] len,
                            logic [7:0] st);
      int          n0;
      int          lg;
      int          c;
      seq_phase_t  old;
      logic [31:0] fbytes;
      logic [31:0] room;
      n0  = expected_actions.size();
      old = phase;
      n_events++;
      case (phase)
        SEQ_IDLE: begin
          if (op == fpes_pkg::OP_WRITE) begin
            lg     = (size_log2 > fpes_pkg::SizeLog2Max) ?
                     fpes_pkg::SizeLog2Max : int'(size_log2);
            fbytes = 32'd1 << lg;
            room   = fpes_pkg::SectorBytes - (adr % fpes_pkg::SectorBytes);
            if (adr > fbytes || len > fbytes - adr) finish_op(fpes_pkg::ERR_ADDR);
            else if (len > room) finish_op(fpes_pkg::ERR_CROSS);
            else if (len == 0) finish_op(fpes_pkg::ERR_OK);
            else begin
              is_erase   = 1'b0;
              cur_addr   = adr;
              bytes_left = len;
              bytes_done = '0;
              start_enable();
            end
          end else if (op == fpes_pkg::OP_ERASE) begin
            is_erase   = 1'b1;
            cur_addr   = adr;
            bytes_left = '0;
            bytes_done = '0;
            start_enable();
          end
        end
        SEQ_WAIT_WEL: begin
          if (op == fpes_pkg::OP_STATUS) begin
            if (!st[fpes_pkg::StWelBit]) finish_op(fpes_pkg::ERR_WEL);
            else begin
              if (is_erase) begin
                push(fpes_pkg::ACT_SECTOR_ERASE, cur_addr, '0, '0, fpes_pkg::ERR_OK);
                polls_left = fpes_pkg::PollsErase;
              end else begin
                push(fpes_pkg::ACT_PAGE_PROGRAM, cur_addr, CW'(chunk_bytes()), bytes_done,
                     fpes_pkg::ERR_OK);
                polls_left = fpes_pkg::PollsProgram;
              end
              phase = SEQ_WAIT_TICK;
            end
          end
        end
        SEQ_WAIT_TICK: begin
          if (op == fpes_pkg::OP_TICK) begin
            push(fpes_pkg::ACT_READ_STATUS, '0, '0, '0, fpes_pkg::ERR_OK);
            phase = SEQ_WAIT_POLL;
          end
        end
        SEQ_WAIT_POLL: begin
          if (op == fpes_pkg::OP_STATUS) begin
            if (!st[fpes_pkg::StBusyBit]) begin
              if (is_erase) finish_op(fpes_pkg::ERR_OK);
              else begin
                c          = chunk_bytes();
                cur_addr   = cur_addr + AW'(c);
                bytes_done = bytes_done + OW'(c);
                bytes_left = bytes_left - LW'(c);
                if (bytes_left == 0) finish_op(fpes_pkg::ERR_OK);
                else start_enable();
              end
            end else begin
              if (polls_left != 0) polls_left--;
              if (polls_left == 0) finish_op(fpes_pkg::ERR_TIMEOUT);
              else phase = SEQ_WAIT_TICK;
            end
          end
        end
        default: phase = SEQ_IDLE;
      endcase
      if (expected_actions.size() > n0)
        expected_actions[expected_actions.size() - 1].last = 1'b1;
      return (expected_actions.size() != n0) || (phase != old);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_action(fpes_pkg::result_t got);
      fpes_pkg::result_t want;
      n_results++;
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual action %0d tdata fields %h",
                 $time, got.action, got);
        errors++;
        return;
      end
      want = expected_actions.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("target_address", want.target_address, got.target_address);
      compare_field("chunk_length", want.chunk_length, got.chunk_length);
      compare_field("buffer_offset", want.buffer_offset, got.buffer_offset);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  flash_action_scoreboard sb;
  bit                idle_on;
  bit                stuck;
  bit                force_erase_timeout;
  bit                last_acted;
  int                stall_left;
  int                quiet_cycles;
  int                n_cfg;
  fpes_pkg::result_t seen_action;

  flash_program_erase_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // check results, stall the result stream in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_action = {out_tuser, out_tdata[23:0], out_tdata[32:24], out_tdata[44:33],
                     out_tdata[47:45], out_tlast};
      sb.check_action(seen_action);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("flash_program_erase_sequencer test failed");
      $finish;
    end
  end

  task automatic send_event(fpes_pkg::opcode_t op, logic [AW-1:0] adr, logic [LW-1:0] len,
                            logic [7:0] st);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, st, len, adr};
    do @(posedge clk); while (!in_tready);
    last_acted = sb.note_event(op, adr, len, st);
  endtask

  task automatic write_reg(bit idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    n_cfg++;
  endtask

  task automatic configure(logic [4:0] lg, logic [8:0] lim);
    write_reg(fpes_pkg::CfgSizeLog2, {4'b0000, lg});
    write_reg(fpes_pkg::CfgChunkLimit, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic drive_to_idle();
    while (sb.phase != SEQ_IDLE) begin
      if (sb.phase == SEQ_WAIT_TICK) send_event(fpes_pkg::OP_TICK, '0, '0, 8'h00);
      else send_event(fpes_pkg::OP_STATUS, '0, '0, 8'h00);
    end
  endtask

  task automatic random_step();
    fpes_pkg::opcode_t op;
    logic [AW-1:0]     adr;
    logic [LW-1:0]     len;
    logic [7:0]        st;
    logic [31:0]       fbytes;
    logic [31:0]       room;
    logic [31:0]       lenmax;
    int                lg;
    int                lim;
    int                pick;
    int                shape;
    pick = $urandom_range(0, 99);
    op   = fpes_pkg::opcode_t'($urandom_range(0, 3));
    adr  = AW'($urandom);
    len  = LW'($urandom);
    st   = 8'($urandom);
    case (sb.phase)
      SEQ_IDLE: begin
        lg     = (sb.size_log2 > fpes_pkg::SizeLog2Max) ?
                 fpes_pkg::SizeLog2Max : int'(sb.size_log2);
        fbytes = 32'd1 << lg;
        lim    = (sb.chunk_limit == 0) ? 1 : int'(sb.chunk_limit);
        if (force_erase_timeout) begin
          op = fpes_pkg::OP_ERASE;
          stuck = 1'b1;
          force_erase_timeout = 1'b0;
        end else if (pick < 45) begin
          op    = fpes_pkg::OP_WRITE;
          stuck = ($urandom_range(0, 99) == 0);
          shape = $urandom_range(0, 19);
          if (shape < 15) begin
            adr = AW'($urandom & (fbytes - 1));
            if (shape == 0 && lg >= 12) adr[11:0] = '0;
            else if (shape < 4 && lg >= 8) adr[7:0] = {4'hF, 4'($urandom)};
            room   = fpes_pkg::SectorBytes - (adr % fpes_pkg::SectorBytes);
            lenmax = room;
            if (fbytes - adr < lenmax) lenmax = fbytes - adr;
            if (lenmax > lim * 16) lenmax = lim * 16;
            if (shape >= 4 && lenmax > 64) lenmax = 64;
            if (shape == 0) len = LW'(lenmax);
            else if ($urandom_range(0, 49) == 0) len = '0;
            else len = LW'($urandom_range(1, lenmax));
          end else if (shape == 15) begin
            adr = AW'(fbytes);
            len = LW'($urandom_range(0, 2));
          end else begin
            room = fpes_pkg::SectorBytes - (adr % fpes_pkg::SectorBytes);
            if (adr <= fbytes && len <= fbytes - adr && len <= room)
              len = LW'(room + 1 + ($urandom % (8191 - room)));
          end
        end else if (pick < 80) begin
          op    = fpes_pkg::OP_ERASE;
          stuck = 1'b0;
        end else begin
          op = ($urandom_range(0, 1) != 0) ? fpes_pkg::OP_STATUS : fpes_pkg::OP_TICK;
        end
      end
      SEQ_WAIT_WEL: begin
        if (pick < 88) begin
          op = fpes_pkg::OP_STATUS;
          st[fpes_pkg::StWelBit] = ($urandom_range(0, 15) != 0);
        end
        if (stuck) st[fpes_pkg::StWelBit] = 1'b1;
      end
      SEQ_WAIT_TICK: begin
        if (pick < 88) op = fpes_pkg::OP_TICK;
      end
      default: begin
        if (pick < 88) begin
          op = fpes_pkg::OP_STATUS;
          st[fpes_pkg::StBusyBit] = ($urandom_range(0, 2) == 0);
        end
        if (stuck) st[fpes_pkg::StBusyBit] = 1'b1;
      end
    endcase
    send_event(op, adr, len, st);
  endtask

  initial begin
    int p;
    int n;
    sb = new();
    idle_on = 1'b1;
    stuck = 1'b0;
    force_erase_timeout = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    n_cfg = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= fpes_pkg::OP_WRITE;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= fpes_pkg::CfgSizeLog2;
    cfg_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at reset settings
    send_event(fpes_pkg::OP_WRITE, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_WRITE, 24'hFFFFFF, 13'd2, 8'h00);
    send_event(fpes_pkg::OP_WRITE, 24'h000F00, 13'h101, 8'h00);
    send_event(fpes_pkg::OP_WRITE, 24'h000000, 13'h1FFF, 8'h00);
    send_event(fpes_pkg::OP_ERASE, 24'hFFFFFF, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_WRITE, 24'h000000, 13'd1, 8'h00);
    send_event(fpes_pkg::OP_TICK, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h02);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_TICK, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h03);
    send_event(fpes_pkg::OP_TICK, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'hFE);
    send_event(fpes_pkg::OP_WRITE, 24'h0000F0, 13'h030, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'hFD);
    send_event(fpes_pkg::OP_WRITE, 24'hFFF0F0, 13'h030, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h02);
    send_event(fpes_pkg::OP_TICK, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'hFF);
    send_event(fpes_pkg::OP_ERASE, 24'h123456, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_TICK, 24'h000000, 13'd0, 8'h00);
    send_event(fpes_pkg::OP_STATUS, 24'h000000, 13'd0, 8'h02);

    for (p = 0; p < 8; p++) begin
      drive_to_idle();
      settle();
      case (p)
        1: configure(5'd12, 9'd1);
        2: configure(5'd24, 9'd256);
        3: configure(5'd31, 9'd0);
        4: configure(5'($urandom_range(0, 11)), 9'd511);
        5: configure(5'($urandom_range(12, 24)), 9'($urandom_range(1, 256)));
        6: configure(5'($urandom_range(25, 31)), 9'($urandom_range(2, 16)));
        7: configure(5'($urandom_range(12, 24)), 9'($urandom_range(1, 511)));
        default: ;
      endcase
      idle_on = (p != 7);
      force_erase_timeout = (p == 2);
      n = 0;
      while ((n < ItemsPerSetting) || (stuck && (sb.phase != SEQ_IDLE))) begin
        random_step();
        if (last_acted) n++;
      end
    end
    drive_to_idle();
    settle();

    if (sb.expected_actions.size() != 0) begin
      $display("%0t: expected %0d more results, actual 0", $time, sb.expected_actions.size());
      sb.errors++;
    end
    $display("Ran %0d events, %0d results, %0d register writes over eight settings.",
             sb.n_events, sb.n_results, n_cfg);
    $display("Finished codes: ok %0d, bad address %0d, sector cross %0d, no WEL %0d, timeout %0d",
             sb.finishes[0], sb.finishes[1], sb.finishes[2], sb.finishes[3], sb.finishes[4]);
    if (sb.errors == 0) begin
      $display("flash_program_erase_sequencer test passed");
    end else begin
      $display("flash_program_erase_sequencer test failed");
    end
    $finish;
  end

endmodule
